>>> design/tape_machine_execution_unit_defines.svh
// assertion macros for the tape machine execution unit
`ifndef TAPE_MACHINE_EXECUTION_UNIT_DEFINES_SVH
`define TAPE_MACHINE_EXECUTION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define TMEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TMEU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TMEU_ASSERT(lbl, prop, msg)
`define TMEU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/tmeu_pkg.sv
// shared types and constants of the tape machine execution unit
package tmeu_pkg;

  localparam int unsigned TAPE_HALF_DEF = 256;
  localparam logic [16:0] PROG_DEPTH    = 17'd65536;

  localparam int unsigned CELL_W = 32;
  localparam int unsigned PC_W   = 16;

  localparam logic [3:0] OP_INC         = 4'd0;
  localparam logic [3:0] OP_DEC         = 4'd1;
  localparam logic [3:0] OP_ADD         = 4'd2;
  localparam logic [3:0] OP_SUB         = 4'd3;
  localparam logic [3:0] OP_LEFT        = 4'd4;
  localparam logic [3:0] OP_RIGHT       = 4'd5;
  localparam logic [3:0] OP_JNZ         = 4'd6;
  localparam logic [3:0] OP_JZ          = 4'd7;
  localparam logic [3:0] OP_IN          = 4'd8;
  localparam logic [3:0] OP_OUT         = 4'd9;
  localparam logic [3:0] OP_UNCOMPLETED = 4'd10;

  localparam logic [1:0] STAT_RUNNING  = 2'd0;
  localparam logic [1:0] STAT_FINISHED = 2'd1;
  localparam logic [1:0] STAT_UNCOMP   = 2'd2;
  localparam logic [1:0] STAT_RANGE    = 2'd3;

  typedef struct packed {
    logic [PC_W-1:0] next_pc;
    logic            out_valid;
    logic [7:0]      out_byte;
    logic [1:0]      status;
  } res_t;

  typedef struct packed {
    logic              cell_we;
    logic [CELL_W-1:0] cell_wdata;
    logic              move_left;
    logic              move_right;
    logic              stop_set;
    logic [1:0]        stop_code;
    res_t              res;
  } exec_t;

endpackage

>>> design/tmeu_ram.sv
// generic simple dual-port ram with registered read
module tmeu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tmeu_exec.sv
// instruction decode and cell update of the tape machine
module tmeu_exec (
  input  logic [3:0]                  op_i,
  input  logic [15:0]                 arg_i,
  input  logic signed [8:0]           in_value_i,
  input  logic [tmeu_pkg::CELL_W-1:0] cell_i,
  input  logic [tmeu_pkg::PC_W-1:0]   pc_i,
  input  logic [15:0]                 plen_i,
  input  logic                        stopped_i,
  input  logic [1:0]                  stop_code_i,
  input  logic                        at_left_i,
  input  logic                        at_right_i,
  output tmeu_pkg::exec_t             ex_o
);

  function automatic logic is_done(input logic [15:0] pc, input logic [15:0] plen);
    is_done = (pc >= plen) || ({1'b0, pc} >= tmeu_pkg::PROG_DEPTH);
  endfunction

  logic [tmeu_pkg::PC_W-1:0]   pc_inc;
  logic [tmeu_pkg::PC_W-1:0]   pc_new;
  logic [tmeu_pkg::CELL_W-1:0] in_cell;
  logic [tmeu_pkg::CELL_W-1:0] arg_ext;
  logic                        cell_zero;

  assign pc_inc    = pc_i + 16'd1;
  assign in_cell   = {{(tmeu_pkg::CELL_W-9){in_value_i[8]}}, in_value_i};
  assign arg_ext   = {{(tmeu_pkg::CELL_W-16){1'b0}}, arg_i};
  assign cell_zero = (cell_i == '0);

  always_comb begin
    ex_o             = '0;
    pc_new           = pc_i;
    ex_o.res.next_pc = pc_i;
    if (stopped_i) begin
      ex_o.res.status = stop_code_i;
    end else if (is_done(pc_i, plen_i)) begin
      ex_o.res.status = tmeu_pkg::STAT_FINISHED;
    end else begin
      case (op_i)
        tmeu_pkg::OP_INC: begin
          ex_o.cell_we    = 1'b1;
          ex_o.cell_wdata = cell_i + 32'd1;
          pc_new          = pc_inc;
        end
        tmeu_pkg::OP_DEC: begin
          ex_o.cell_we    = 1'b1;
          ex_o.cell_wdata = cell_i - 32'd1;
          pc_new          = pc_inc;
        end
        tmeu_pkg::OP_ADD: begin
          ex_o.cell_we    = 1'b1;
          ex_o.cell_wdata = cell_i + arg_ext;
          pc_new          = pc_inc;
        end
        tmeu_pkg::OP_SUB: begin
          ex_o.cell_we    = 1'b1;
          ex_o.cell_wdata = cell_i - arg_ext;
          pc_new          = pc_inc;
        end
        tmeu_pkg::OP_LEFT: begin
          if (at_left_i) begin
            ex_o.stop_set  = 1'b1;
            ex_o.stop_code = tmeu_pkg::STAT_RANGE;
          end else begin
            ex_o.move_left = 1'b1;
            pc_new         = pc_inc;
          end
        end
        tmeu_pkg::OP_RIGHT: begin
          if (at_right_i) begin
            ex_o.stop_set  = 1'b1;
            ex_o.stop_code = tmeu_pkg::STAT_RANGE;
          end else begin
            ex_o.move_right = 1'b1;
            pc_new          = pc_inc;
          end
        end
        tmeu_pkg::OP_JNZ: begin
          pc_new = cell_zero ? pc_inc : arg_i;
        end
        tmeu_pkg::OP_JZ: begin
          pc_new = cell_zero ? arg_i : pc_inc;
        end
        tmeu_pkg::OP_IN: begin
          ex_o.cell_we    = 1'b1;
          ex_o.cell_wdata = in_cell;
          pc_new          = pc_inc;
        end
        tmeu_pkg::OP_OUT: begin
          ex_o.res.out_valid = 1'b1;
          ex_o.res.out_byte  = cell_i[7:0];
          pc_new             = pc_inc;
        end
        tmeu_pkg::OP_UNCOMPLETED: begin
          ex_o.stop_set  = 1'b1;
          ex_o.stop_code = tmeu_pkg::STAT_UNCOMP;
        end
        default: begin
          ex_o.stop_set  = 1'b1;
          ex_o.stop_code = tmeu_pkg::STAT_UNCOMP;
        end
      endcase
      ex_o.res.next_pc = pc_new;
      if (ex_o.stop_set) begin
        ex_o.res.status = ex_o.stop_code;
      end else if (is_done(pc_new, plen_i)) begin
        ex_o.res.status = tmeu_pkg::STAT_FINISHED;
      end else begin
        ex_o.res.status = tmeu_pkg::STAT_RUNNING;
      end
    end
  end

endmodule

>>> design/tape_machine_execution_unit.sv
// top level of the tape machine execution unit
// A new instruction word is taken only in the issue state while the second result register
// is empty, so a word is not taken before the previous one is through: the issue state reads
// the cell under the head from the tape memory, the update state updates it, writes it back
// and moves the head or counter. The result word is registered; a second result register lets
// a new word enter while the previous result still waits. After reset the unit zeroes the home
// cell in its init state and then takes words. Cells are zeroed as the head first reaches them,
// so no full clearing pass is needed. Configuration writes are taken at any time.
`include "tape_machine_execution_unit_defines.svh"

module tape_machine_execution_unit #(
  parameter int unsigned TAPE_HALF = tmeu_pkg::TAPE_HALF_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // argument[15:0], in_value[24:16], zero pad
  input  logic [3:0]  s_axis_tuser,  // opcode[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // next_pc[15:0], out_byte[23:16]
  output logic [2:0]  m_axis_tuser   // out_valid[0], status[2:1]
);

  localparam int unsigned Cells = 2 * TAPE_HALF;
  localparam int unsigned IdxW  = $clog2(Cells);
  localparam logic [IdxW-1:0] IdxHome = IdxW'(TAPE_HALF);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(Cells - 1);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_ISSUE,
    ST_UPDATE
  } state_e;

  state_e                      state_q, state_d;
  logic [3:0]                  op_q, op_d;
  logic [15:0]                 arg_q, arg_d;
  logic signed [8:0]           inv_q, inv_d;
  logic [tmeu_pkg::PC_W-1:0]   pc_q, pc_d;
  logic [IdxW-1:0]             idx_q, idx_d;
  logic [IdxW-1:0]             lo_q, lo_d;
  logic [IdxW-1:0]             hi_q, hi_d;
  logic                        stopped_q, stopped_d;
  logic [1:0]                  stop_code_q, stop_code_d;
  logic [15:0]                 plen_q, plen_d;
  logic                        out_v_q, out_v_d;
  tmeu_pkg::res_t              out_q, out_d;
  logic                        skid_v_q, skid_v_d;
  tmeu_pkg::res_t              skid_q, skid_d;

  logic                        accept;
  logic                        take;
  logic                        res_valid;
  logic                        ram_we;
  logic [IdxW-1:0]             ram_waddr;
  logic [tmeu_pkg::CELL_W-1:0] ram_wdata;
  logic [tmeu_pkg::CELL_W-1:0] cell_rd;
  tmeu_pkg::exec_t             ex;

  assign s_axis_tready = (state_q == ST_ISSUE) && !skid_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_v_q && m_axis_tready;
  assign res_valid     = (state_q == ST_UPDATE);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.out_byte, out_q.next_pc};
  assign m_axis_tuser  = {out_q.status, out_q.out_valid};

  tmeu_ram #(
    .Width (tmeu_pkg::CELL_W),
    .Depth (Cells)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (idx_q),
    .rdata_o (cell_rd)
  );

  tmeu_exec u_exec (
    .op_i        (op_q),
    .arg_i       (arg_q),
    .in_value_i  (inv_q),
    .cell_i      (cell_rd),
    .pc_i        (pc_q),
    .plen_i      (plen_q),
    .stopped_i   (stopped_q),
    .stop_code_i (stop_code_q),
    .at_left_i   (idx_q == '0),
    .at_right_i  (idx_q == IdxLast),
    .ex_o        (ex)
  );

  // tape memory write: home cell zeroing, cell update, or zeroing a newly reached cell
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ex.cell_wdata;
    if (state_q == ST_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = IdxHome;
      ram_wdata = '0;
    end else if (res_valid) begin
      if (ex.cell_we) begin
        ram_we = 1'b1;
      end else if (ex.move_left && (idx_q == lo_q)) begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - 1'b1;
        ram_wdata = '0;
      end else if (ex.move_right && (idx_q == hi_q)) begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + 1'b1;
        ram_wdata = '0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    arg_d       = arg_q;
    inv_d       = inv_q;
    pc_d        = pc_q;
    idx_d       = idx_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    stopped_d   = stopped_q;
    stop_code_d = stop_code_q;
    plen_d      = cfg_we_i ? cfg_wdata_i : plen_q;
    out_v_d     = out_v_q;
    out_d       = out_q;
    skid_v_d    = skid_v_q;
    skid_d      = skid_q;

    case (state_q)
      ST_INIT: begin
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (accept) begin
          op_d    = s_axis_tuser;
          arg_d   = s_axis_tdata[15:0];
          inv_d   = s_axis_tdata[24:16];
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_ISSUE;
        pc_d    = ex.res.next_pc;
        if (ex.stop_set) begin
          stopped_d   = 1'b1;
          stop_code_d = ex.stop_code;
        end
        if (ex.move_left) begin
          idx_d = idx_q - 1'b1;
          if (idx_q == lo_q) begin
            lo_d = idx_q - 1'b1;
          end
        end
        if (ex.move_right) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == hi_q) begin
            hi_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_ISSUE;
      end
    endcase

    // result word buffering
    if (take) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
        if (res_valid) begin
          skid_d   = ex.res;
          skid_v_d = 1'b1;
        end
      end else if (res_valid) begin
        out_d = ex.res;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_q) begin
        out_d   = ex.res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = ex.res;
        skid_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      pc_q        <= '0;
      idx_q       <= IdxHome;
      lo_q        <= IdxHome;
      hi_q        <= IdxHome;
      stopped_q   <= 1'b0;
      stop_code_q <= tmeu_pkg::STAT_RUNNING;
      plen_q      <= '0;
      out_v_q     <= 1'b0;
      skid_v_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      stopped_q   <= stopped_d;
      stop_code_q <= stop_code_d;
      plen_q      <= plen_d;
      out_v_q     <= out_v_d;
      skid_v_q    <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    arg_q  <= arg_d;
    inv_q  <= inv_d;
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `TMEU_ASSERT_ALWAYS(a_head_in_range, (lo_q <= idx_q) && (idx_q <= hi_q), "head outside zeroed range")
  `TMEU_ASSERT_ALWAYS(a_skid_behind_out, !skid_v_q || out_v_q, "second result without first")
  `TMEU_ASSERT(a_accept_update, accept |=> (state_q == ST_UPDATE), "accepted word not executed")
  `TMEU_ASSERT(a_stop_holds, stopped_q |=> (stopped_q && $stable(pc_q)), "stopped unit moved on")

endmodule

>>> sim/tape_machine_execution_unit_test.sv
// self-checking stream testbench for the tape machine execution unit
module tape_machine_execution_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TH = tmeu_pkg::TAPE_HALF_DEF;
  localparam logic [3:0] OP_LAST_CODE = 4'hF;
  localparam logic [8:0] END_OF_INPUT = 9'h1FF;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [3:0] RUN_OPS [10] = '{tmeu_pkg::OP_INC, tmeu_pkg::OP_DEC,
                                          tmeu_pkg::OP_ADD, tmeu_pkg::OP_SUB,
                                          tmeu_pkg::OP_LEFT, tmeu_pkg::OP_RIGHT,
                                          tmeu_pkg::OP_JNZ, tmeu_pkg::OP_JZ,
                                          tmeu_pkg::OP_IN, tmeu_pkg::OP_OUT};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // argument[15:0], in_value[24:16], zero pad
  logic [3:0]  s_axis_tuser;  // opcode[3:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // next_pc[15:0], out_byte[23:16]
  logic [2:0]  m_axis_tuser;  // out_valid[0], status[2:1]

  bit steady;
  bit hold_off;
  bit walk_end;

  class tape_shadow;
    logic [31:0]    cells [2*TH];
    int             pos;
    logic [15:0]    pc;
    logic [15:0]    prog_len;
    bit             halted;
    logic [1:0]     halt_code;
    tmeu_pkg::res_t due_results [$];
    int unsigned    mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      pos        = 0;
      pc         = '0;
      prog_len   = '0;
      halted     = 1'b0;
      halt_code  = tmeu_pkg::STAT_RUNNING;
      mismatches = 0;
    endfunction

    function void take_instr(logic [3:0] op, logic [15:0] arg, logic [8:0] inval);
      tmeu_pkg::res_t want;
      logic [15:0]    step_pc;
      int             slot;
      want    = '0;
      step_pc = pc + 16'd1;
      slot    = pos + TH;
      if (halted) begin
        want.status = halt_code;
      end else if (pc >= prog_len) begin
        want.status = tmeu_pkg::STAT_FINISHED;
      end else begin
        case (op)
          tmeu_pkg::OP_INC: begin
            cells[slot] += 32'd1;
            pc = step_pc;
          end
          tmeu_pkg::OP_DEC: begin
            cells[slot] -= 32'd1;
            pc = step_pc;
          end
          tmeu_pkg::OP_ADD: begin
            cells[slot] += {16'd0, arg};
            pc = step_pc;
          end
          tmeu_pkg::OP_SUB: begin
            cells[slot] -= {16'd0, arg};
            pc = step_pc;
          end
          tmeu_pkg::OP_LEFT: begin
            if (pos == -TH) begin
              halted    = 1'b1;
              halt_code = tmeu_pkg::STAT_RANGE;
            end else begin
              pos--;
              pc = step_pc;
            end
          end
          tmeu_pkg::OP_RIGHT: begin
            if (pos == TH - 1) begin
              halted    = 1'b1;
              halt_code = tmeu_pkg::STAT_RANGE;
            end else begin
              pos++;
              pc = step_pc;
            end
          end
          tmeu_pkg::OP_JNZ: pc = (cells[slot] != 32'd0) ? arg : step_pc;
          tmeu_pkg::OP_JZ:  pc = (cells[slot] == 32'd0) ? arg : step_pc;
          tmeu_pkg::OP_IN: begin
            cells[slot] = {{23{inval[8]}}, inval};
            pc = step_pc;
          end
          tmeu_pkg::OP_OUT: begin
            want.out_valid = 1'b1;
            want.out_byte  = cells[slot][7:0];
            pc = step_pc;
          end
          default: begin
            halted    = 1'b1;
            halt_code = tmeu_pkg::STAT_UNCOMP;
          end
        endcase
        if (halted) want.status = halt_code;
        else want.status = (pc >= prog_len) ? tmeu_pkg::STAT_FINISHED : tmeu_pkg::STAT_RUNNING;
      end
      want.next_pc = pc;
      due_results.push_back(want);
    endfunction

    function void check_result(tmeu_pkg::res_t got);
      tmeu_pkg::res_t want;
      if (due_results.size() == 0) begin
        $error("result word with nothing outstanding: next_pc %0d", got.next_pc);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.next_pc !== want.next_pc) begin
        $error("next_pc mismatch: expected %0d, got %0d", want.next_pc, got.next_pc);
        mismatches++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid mismatch: expected %0d, got %0d", want.out_valid, got.out_valid);
        mismatches++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte mismatch: expected %0h, got %0h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  tape_shadow sb;

  tape_machine_execution_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.prog_len = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        sb.take_instr(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[24:16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result({m_axis_tdata[15:0], m_axis_tuser[0], m_axis_tdata[23:16],
                         m_axis_tuser[2:1]});
      end
    end
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // shorter random phases when the run ends with a walk to the tape edge
  function automatic int unsigned phase_len(input int unsigned n);
    return walk_end ? n / 2 : n;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall;
    stall = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic idle_gap();
    int unsigned n;
    n = 0;
    if (!steady && $urandom_range(0, 2) == 0) n = pick_gap();
    if (n != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // called at a falling edge; returns at the edge that takes the word
  task automatic offer(input logic [3:0] op, input logic [15:0] arg, input logic [8:0] inval);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, inval, arg};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_word(input logic [3:0] op, input logic [15:0] arg,
                           input logic [8:0] inval);
    idle_gap();
    @(negedge clk_i);
    offer(op, arg, inval);
  endtask

  task automatic send_random();
    logic [3:0]  op;
    logic [15:0] arg;
    logic [8:0]  inval;
    int unsigned lo;
    idle_gap();
    @(negedge clk_i);
    op = RUN_OPS[$urandom_range(0, 9)];
    if (op == tmeu_pkg::OP_LEFT && sb.pos == -TH) op = tmeu_pkg::OP_RIGHT;
    else if (op == tmeu_pkg::OP_RIGHT && sb.pos == TH - 1) op = tmeu_pkg::OP_LEFT;
    if (op == tmeu_pkg::OP_JNZ || op == tmeu_pkg::OP_JZ) begin
      lo  = (sb.pc > 16) ? sb.pc - 16 : 0;
      arg = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(lo, sb.pc + 3))
                                        : 16'($urandom_range(0, 60000));
    end else if ($urandom_range(0, 1) == 0) begin
      arg = 16'($urandom_range(0, 15));
    end else begin
      arg = 16'($urandom);
    end
    inval = ($urandom_range(0, 9) == 0) ? END_OF_INPUT : 9'($urandom_range(0, 255));
    offer(op, arg, inval);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < 4000 && sb.due_results.size() != 0; k++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [15:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] len, input int unsigned count, input bit quiet);
    steady = quiet;
    write_length(len);
    repeat (count) send_random();
    settle();
    steady = 1'b0;
  endtask

  function automatic logic [15:0] near_end();
    int unsigned v;
    v = sb.pc + $urandom_range(5, 40);
    return (v > 65534) ? 16'hFFFE : 16'(v);
  endfunction

  initial begin
    logic [3:0] dir;
    sb = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;
    hold_off      = 1'b0;
    walk_end      = ($urandom_range(0, 1) == 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero length after reset: nothing runs
    repeat (3) send_word(tmeu_pkg::OP_INC, 16'hFFFF, 9'h0FF);
    settle();

    write_length(16'hFFFF);
    send_word(tmeu_pkg::OP_INC, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_OUT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_DEC, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_DEC, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_OUT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_ADD, 16'hFFFF, 9'd0);
    send_word(tmeu_pkg::OP_OUT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_SUB, 16'hFFFF, 9'd0);
    send_word(tmeu_pkg::OP_SUB, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_JZ, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_JNZ, 16'd40, 9'd0);
    send_word(tmeu_pkg::OP_IN, 16'd0, 9'd255);
    send_word(tmeu_pkg::OP_OUT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_IN, 16'd0, END_OF_INPUT);
    send_word(tmeu_pkg::OP_OUT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_IN, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_JZ, 16'd7, 9'd0);
    send_word(tmeu_pkg::OP_JNZ, 16'hFFFF, 9'd0);
    send_word(tmeu_pkg::OP_LEFT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_LEFT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_OUT, 16'd0, 9'd0);
    repeat (3) send_word(tmeu_pkg::OP_RIGHT, 16'd0, 9'd0);
    send_word(tmeu_pkg::OP_ADD, 16'd1, 9'd0);
    settle();

    run_phase(16'hFFFF, phase_len(80), 1'b0);
    hold_off = 1'b1;
    run_phase(16'hFFFF, phase_len(60), 1'b1);
    run_phase(near_end(), phase_len(70), 1'b0);
    run_phase(16'h0000, 8, 1'b0);
    run_phase(16'($urandom_range(sb.pc + 1, 65534)), phase_len(70), 1'b1);
    run_phase(near_end(), phase_len(70), 1'b0);
    run_phase(16'hFFFF, phase_len(80), 1'b0);

    // end on a fault, then confirm the unit stays stopped
    write_length(16'hFFFF);
    if (!walk_end) begin
      send_word(4'($urandom_range(tmeu_pkg::OP_UNCOMPLETED, OP_LAST_CODE)), 16'($urandom),
                9'($urandom));
    end else begin
      dir = (sb.pos < 0) ? tmeu_pkg::OP_LEFT : tmeu_pkg::OP_RIGHT;
      while (!sb.halted) send_word(dir, 16'($urandom), 9'($urandom));
    end
    repeat (6) send_random();
    settle();

    if (sb.due_results.size() != 0) begin
      $error("%0d result words never arrived", sb.due_results.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/tmeu_pkg.sv
design/tmeu_ram.sv
design/tmeu_exec.sv
design/tape_machine_execution_unit.sv
sim/tape_machine_execution_unit_test.sv
